/* rtl/core/ctt_pkg.sv */
// ctt_pkg: shared constants, operation codes and controller/datapath types
// for the countdown timer table. No dependencies; compiled first.

package ctt_pkg;

    // default table depth and mask width
    localparam int TIMERS_DEF = 8;
    localparam int MASK_BITS  = 8;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HANDLER = 8'd1;

    // operation codes
    localparam logic [2:0] OP_SET_TENTHS = 3'd0;
    localparam logic [2:0] OP_SET_MST    = 3'd1;
    localparam logic [2:0] OP_START      = 3'd2;
    localparam logic [2:0] OP_STOP       = 3'd3;
    localparam logic [2:0] OP_RELOAD     = 3'd4;
    localparam logic [2:0] OP_CHECK      = 3'd5;
    localparam logic [2:0] OP_TICK       = 3'd6;
    localparam logic [2:0] OP_SERVICE    = 3'd7;

    // datapath actions
    typedef logic [2:0] t_dp_act;
    localparam t_dp_act ACT_NONE    = 3'd0;
    localparam t_dp_act ACT_EXEC    = 3'd1;
    localparam t_dp_act ACT_TICK    = 3'd2;
    localparam t_dp_act ACT_SERVE   = 3'd3;
    localparam t_dp_act ACT_CHK_OUT = 3'd4;

    // cycles the digit pipeline needs before a check result is ready
    localparam logic [2:0] CHK_LAT = 3'd5;

    typedef struct packed {
        logic    capture;
        t_dp_act act;
        logic    sel_inc;
    } t_dp_cmd;

    typedef struct packed {
        logic fire;
        logic sel_last;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/core/ctt_in_if.sv */
// ctt_in_if: input channel carrying one timer operation per transaction.
// Standalone; widths follow the operation item fields.

interface ctt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [7:0]  timer_index;
    logic [15:0] tenths_amount;
    logic [7:0]  minutes;
    logic [7:0]  seconds;

    modport source (output valid, operation, timer_index, tenths_amount, minutes, seconds,
                    input ready);
    modport sink   (input valid, operation, timer_index, tenths_amount, minutes, seconds,
                    output ready);
endinterface

/* rtl/core/ctt_out_if.sv */
// ctt_out_if: result channel, one check report or fired timer per transaction.
// Standalone; widths follow the result item fields.

interface ctt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  which_timer;
    logic [15:0] remaining;
    logic        fired;
    logic [3:0]  minute_tens;
    logic [3:0]  minute_ones;
    logic [2:0]  second_tens;
    logic [3:0]  second_ones;
    logic [3:0]  tenth_digit;
    logic        last;

    modport source (output valid, which_timer, remaining, fired, minute_tens, minute_ones,
                    second_tens, second_ones, tenth_digit, last, input ready);
    modport sink   (input valid, which_timer, remaining, fired, minute_tens, minute_ones,
                    second_tens, second_ones, tenth_digit, last, output ready);
endinterface

/* rtl/core/ctt_cfg_if.sv */
// ctt_cfg_if: register write channel (index and data).
// Depends on ctt_pkg for the field widths.

interface ctt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ctt_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [ctt_pkg::CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

/* rtl/core/ctt_ctrl.sv */
// ctt_ctrl: operation sequencer for the countdown timer table.
// Drives ctt_dp through ctt_pkg::t_dp_cmd and reads back ctt_pkg::t_dp_sts.

module ctt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [2:0]       i_operation,
    output logic             o_in_ready,
    output ctt_pkg::t_dp_cmd o_cmd,
    input  ctt_pkg::t_dp_sts i_sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_TICK  = 3'd3;
    localparam logic [2:0] ST_SERVE = 3'd4;

    logic [2:0] r_state, n_state;
    logic [2:0] r_wait, n_wait;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state       = r_state;
        n_wait        = r_wait;
        o_cmd.capture = 1'b0;
        o_cmd.act     = ctt_pkg::ACT_NONE;
        o_cmd.sel_inc = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_wait        = '0;
                    case (i_operation)
                        ctt_pkg::OP_CHECK:   n_state = ST_CHECK;
                        ctt_pkg::OP_TICK:    n_state = ST_TICK;
                        ctt_pkg::OP_SERVICE: n_state = ST_SERVE;
                        default:             n_state = ST_EXEC;
                    endcase
                end
            end
            ST_EXEC: begin
                o_cmd.act = ctt_pkg::ACT_EXEC;
                n_state   = ST_IDLE;
            end
            ST_CHECK: begin
                // wait for the digit pipeline to settle, then hand over the report
                if (r_wait == ctt_pkg::CHK_LAT) begin
                    if (i_sts.out_free) begin
                        o_cmd.act = ctt_pkg::ACT_CHK_OUT;
                        n_state   = ST_IDLE;
                    end
                end else begin
                    n_wait = r_wait + 3'd1;
                end
            end
            ST_TICK: begin
                o_cmd.act     = ctt_pkg::ACT_TICK;
                o_cmd.sel_inc = 1'b1;
                if (i_sts.sel_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SERVE: begin
                // a firing timer holds the sweep until the result register is free
                if (!i_sts.fire || i_sts.out_free) begin
                    o_cmd.act     = i_sts.fire ? ctt_pkg::ACT_SERVE : ctt_pkg::ACT_NONE;
                    o_cmd.sel_inc = 1'b1;
                    if (i_sts.sel_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= '0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

endmodule

/* rtl/core/ctt_dp.sv */
// ctt_dp: timer table storage, shared decrement/reload path, digit pipeline
// and result register. Depends on ctt_pkg and ctt_out_if.

module ctt_dp #(
    parameter int TIMERS = ctt_pkg::TIMERS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ctt_pkg::t_dp_cmd               i_cmd,
    output ctt_pkg::t_dp_sts               o_sts,
    input  logic [2:0]                     i_operation,
    input  logic [7:0]                     i_timer_index,
    input  logic [15:0]                    i_tenths_amount,
    input  logic [7:0]                     i_minutes,
    input  logic [7:0]                     i_seconds,
    input  logic                           i_cfg_we,
    input  logic [ctt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ctt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ctt_out_if.source                      o_out
);

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    // captured item
    logic [2:0]  r_op;
    logic [7:0]  r_idx;
    logic        r_ok;
    logic [15:0] r_amt;
    logic [17:0] r_mv;

    // table state
    logic [IW-1:0]                   r_sel;
    logic [15:0]                     r_cnt [TIMERS];
    logic [15:0]                     r_rld [TIMERS];
    logic [TIMERS-1:0]               r_run;
    logic [TIMERS-1:0]               r_exp;
    logic [ctt_pkg::CFG_DATA_W-1:0]  r_repeat;
    logic [ctt_pkg::CFG_DATA_W-1:0]  r_handler;

    // digit pipeline
    logic [15:0] r_val;
    logic [6:0]  r_mins;
    logic [9:0]  r_rem;
    logic [3:0]  r_mt;
    logic [5:0]  r_secs;
    logic [3:0]  r_mo;
    logic [2:0]  r_st;
    logic [3:0]  r_td;

    // result register
    logic        r_o_valid;
    logic [2:0]  r_o_which;
    logic [15:0] r_o_rem;
    logic        r_o_fired;
    logic [3:0]  r_o_mt;
    logic [3:0]  r_o_mo;
    logic [2:0]  r_o_st;
    logic [3:0]  r_o_so;
    logic [3:0]  r_o_td;
    logic        r_o_last;

    logic [IW-1:0]     addr;
    logic [15:0]       cur_cnt;
    logic [15:0]       cur_rld;
    logic [TIMERS-1:0] hnd_ext;
    logic [TIMERS-1:0] rep_ext;
    logic [TIMERS-1:0] fire_vec;
    logic [TIMERS-1:0] above;
    logic              fire_now;
    logic              later;
    logic              out_free;
    logic [7:0]        sel8;
    logic [22:0]       mst_prod;
    logic [32:0]       mins_prod;
    logic [15:0]       rem_full;
    logic [14:0]       mt_prod;
    logic [16:0]       secs_prod;
    logic [6:0]        mo_full;
    logic [9:0]        st_prod;
    logic [9:0]        td_full;
    logic [5:0]        so_full;
    logic              load_out;

    // one access port into the table: the sweep counter or the captured index
    assign addr    = (r_op == ctt_pkg::OP_TICK || r_op == ctt_pkg::OP_SERVICE) ?
                     r_sel : r_idx[IW-1:0];
    assign cur_cnt = r_cnt[addr];
    assign cur_rld = r_rld[addr];

    always_comb begin
        for (int j = 0; j < TIMERS; j++) begin
            hnd_ext[j] = (j < ctt_pkg::MASK_BITS) ? r_handler[j % ctt_pkg::MASK_BITS] : 1'b0;
            rep_ext[j] = (j < ctt_pkg::MASK_BITS) ? r_repeat[j % ctt_pkg::MASK_BITS] : 1'b0;
            above[j]   = (j > int'(r_sel));
        end
    end

    assign fire_vec = r_run & r_exp & hnd_ext;
    assign fire_now = fire_vec[r_sel];
    assign later    = |(fire_vec & above);
    assign out_free = !r_o_valid || o_out.ready;
    assign sel8     = 8'(r_sel);

    assign o_sts.fire     = fire_now;
    assign o_sts.sel_last = (r_sel == IW'(TIMERS - 1));
    assign o_sts.out_free = out_free;

    assign mst_prod  = {7'd0, r_mv[15:0]} * 23'd100;
    // val / 600 as a reciprocal multiply, exact for 16-bit values
    assign mins_prod = {17'd0, r_val} * 33'd111849;
    assign rem_full  = r_val - ({9'd0, r_mins} * 16'd600);
    assign mt_prod   = {8'd0, r_mins} * 15'd205;
    assign secs_prod = {7'd0, r_rem} * 17'd205;
    assign mo_full   = r_mins - ({3'd0, r_mt} * 7'd10);
    assign st_prod   = {4'd0, r_secs} * 10'd13;
    assign td_full   = r_rem - ({4'd0, r_secs} * 10'd10);
    assign so_full   = r_secs - ({3'd0, r_st} * 6'd10);

    assign load_out = (i_cmd.act == ctt_pkg::ACT_SERVE) || (i_cmd.act == ctt_pkg::ACT_CHK_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel     <= '0;
            r_run     <= '0;
            r_exp     <= '0;
            r_repeat  <= '0;
            r_handler <= '0;
            r_o_valid <= 1'b0;
            for (int j = 0; j < TIMERS; j++) begin
                r_cnt[j] <= '0;
                r_rld[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == ctt_pkg::REG_REPEAT) begin
                    r_repeat <= i_cfg_data;
                end else if (i_cfg_idx == ctt_pkg::REG_HANDLER) begin
                    r_handler <= i_cfg_data;
                end
            end

            case (i_cmd.act)
                ctt_pkg::ACT_EXEC: begin
                    if (r_ok) begin
                        case (r_op)
                            ctt_pkg::OP_SET_TENTHS: begin
                                r_cnt[addr] <= r_amt;
                                r_rld[addr] <= r_amt;
                            end
                            ctt_pkg::OP_SET_MST: begin
                                r_cnt[addr] <= mst_prod[15:0];
                                r_rld[addr] <= mst_prod[15:0];
                            end
                            ctt_pkg::OP_START:  r_run[addr] <= 1'b1;
                            ctt_pkg::OP_STOP:   r_run[addr] <= 1'b0;
                            ctt_pkg::OP_RELOAD: r_cnt[addr] <= cur_rld;
                            default: ;
                        endcase
                    end
                end
                ctt_pkg::ACT_TICK: begin
                    if (r_run[addr] && cur_cnt != 16'd0) begin
                        r_cnt[addr] <= cur_cnt - 16'd1;
                        if (cur_cnt == 16'd1) begin
                            r_exp[addr] <= 1'b1;
                        end
                    end
                end
                ctt_pkg::ACT_SERVE: begin
                    r_cnt[addr] <= cur_rld;
                    r_exp[addr] <= 1'b0;
                    r_run[addr] <= rep_ext[r_sel];
                end
                default: ;
            endcase

            if (i_cmd.capture) begin
                r_sel <= '0;
            end else if (i_cmd.sel_inc) begin
                r_sel <= r_sel + 1'b1;
            end

            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_operation;
            r_idx <= i_timer_index;
            r_ok  <= (i_timer_index < 8'(TIMERS));
            r_amt <= i_tenths_amount;
            r_mv  <= ({10'd0, i_minutes} * 18'd600) + ({10'd0, i_seconds} * 18'd10)
                     + {10'd0, i_tenths_amount[7:0]};
        end

        // free-running digit split, settles while the check waits
        r_val  <= r_ok ? cur_cnt : 16'd0;
        r_mins <= mins_prod[32:26];
        r_rem  <= rem_full[9:0];
        r_mt   <= mt_prod[14:11];
        r_secs <= secs_prod[16:11];
        r_mo   <= mo_full[3:0];
        r_st   <= st_prod[9:7];
        r_td   <= td_full[3:0];

        if (i_cmd.act == ctt_pkg::ACT_CHK_OUT) begin
            r_o_which <= r_ok ? r_idx[2:0] : 3'd0;
            r_o_rem   <= r_val;
            r_o_fired <= 1'b0;
            r_o_mt    <= r_mt;
            r_o_mo    <= r_mo;
            r_o_st    <= r_st;
            r_o_so    <= so_full[3:0];
            r_o_td    <= r_td;
            r_o_last  <= 1'b1;
        end else if (i_cmd.act == ctt_pkg::ACT_SERVE) begin
            r_o_which <= sel8[2:0];
            r_o_rem   <= '0;
            r_o_fired <= 1'b1;
            r_o_mt    <= '0;
            r_o_mo    <= '0;
            r_o_st    <= '0;
            r_o_so    <= '0;
            r_o_td    <= '0;
            r_o_last  <= !later;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.which_timer = r_o_which;
    assign o_out.remaining   = r_o_rem;
    assign o_out.fired       = r_o_fired;
    assign o_out.minute_tens = r_o_mt;
    assign o_out.minute_ones = r_o_mo;
    assign o_out.second_tens = r_o_st;
    assign o_out.second_ones = r_o_so;
    assign o_out.tenth_digit = r_o_td;
    assign o_out.last        = r_o_last;

endmodule

/* rtl/core/countdown_timer_table_top.sv */
// countdown_timer_table_top: table of countdown timers with check and service reports.
// Depends on ctt_pkg, ctt_in_if, ctt_out_if, ctt_cfg_if, ctt_ctrl and ctt_dp.
//
//   port    direction  carries
//   i_in    sink       operation, timer_index, tenths_amount, minutes, seconds
//   o_out   source     which_timer, remaining, fired, digits, last
//   i_cfg   sink       reg_index, wr_data (0 repeat_mask, 1 handler_mask)
//
// set_tenths, set_mst, start, stop and reload pass through the execute state; check
// waits for the five-stage digit split ahead of the result register; tick and service
// step one timer entry a cycle through the shared update path, service pausing on a
// firing timer while the result register is full. A new transaction is taken once the
// previous one is finished; a waiting result does not block it.
// Synchronous active-low reset clears every timer and both masks.
// A stalled result register holds a check, or holds the service sweep on a firing timer.

module countdown_timer_table_top #(
    parameter int TIMERS = ctt_pkg::TIMERS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ctt_in_if.sink    i_in,
    ctt_out_if.source o_out,
    ctt_cfg_if.sink   i_cfg
);

    ctt_pkg::t_dp_cmd cmd;
    ctt_pkg::t_dp_sts sts;
    logic             in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    ctt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_operation (i_in.operation),
        .o_in_ready  (in_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ctt_dp #(
        .TIMERS (TIMERS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_operation     (i_in.operation),
        .i_timer_index   (i_in.timer_index),
        .i_tenths_amount (i_in.tenths_amount),
        .i_minutes       (i_in.minutes),
        .i_seconds       (i_in.seconds),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_idx       (i_cfg.reg_index),
        .i_cfg_data      (i_cfg.wr_data),
        .o_out           (o_out)
    );

endmodule

/* tb/ctt_tb_pkg.sv */
`timescale 1ns / 1ps
// ctt_tb_pkg: report type and scoreboard for the countdown timer table bench.
// Depends on ctt_pkg for operation codes, register indexes and mask width.

package ctt_tb_pkg;

    typedef struct packed {
        logic [2:0]  which_timer;
        logic [15:0] remaining;
        logic        fired;
        logic [3:0]  minute_tens;
        logic [3:0]  minute_ones;
        logic [2:0]  second_tens;
        logic [3:0]  second_ones;
        logic [3:0]  tenth_digit;
        logic        last;
    } t_timer_report;

    class t_timer_table_scoreboard;
        int unsigned   n_timers;
        logic [15:0]   counter[];
        logic [15:0]   reload_val[];
        bit            enabled[];
        bit            expired_flag[];
        logic [7:0]    repeat_mask;
        logic [7:0]    handler_mask;
        t_timer_report expected_reports[$];
        int unsigned   mismatches;
        int unsigned   checks_seen;
        int unsigned   fires_seen;

        function new(int unsigned timers);
            n_timers     = timers;
            counter      = new[timers];
            reload_val   = new[timers];
            enabled      = new[timers];
            expired_flag = new[timers];
            for (int i = 0; i < timers; i++) begin
                counter[i]      = '0;
                reload_val[i]   = '0;
                enabled[i]      = 1'b0;
                expired_flag[i] = 1'b0;
            end
            repeat_mask  = '0;
            handler_mask = '0;
            mismatches   = 0;
            checks_seen  = 0;
            fires_seen   = 0;
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction

        function void write_reg(logic [ctt_pkg::CFG_IDX_W-1:0] idx,
                                logic [ctt_pkg::CFG_DATA_W-1:0] data);
            if (idx == ctt_pkg::REG_REPEAT) begin
                repeat_mask = data;
            end else if (idx == ctt_pkg::REG_HANDLER) begin
                handler_mask = data;
            end
        endfunction

        // split a count of tenths into MM:SS.T digits
        function t_timer_report make_report(logic [2:0] which, logic [15:0] val,
                                            logic fired, logic last);
            t_timer_report r;
            int unsigned   mins;
            int unsigned   secs;
            mins          = val / 600;
            secs          = (val - mins * 600) / 10;
            r.which_timer = which;
            r.remaining   = val;
            r.fired       = fired;
            r.minute_tens = 4'(mins / 10);
            r.minute_ones = 4'(mins % 10);
            r.second_tens = 3'(secs / 10);
            r.second_ones = 4'(secs % 10);
            r.tenth_digit = 4'(val % 10);
            r.last        = last;
            return r;
        endfunction

        function void apply_operation(logic [2:0] op, logic [7:0] idx, logic [15:0] amount,
                                      logic [7:0] mins, logic [7:0] secs);
            bit                            in_table;
            int unsigned                   total;
            logic [ctt_pkg::MASK_BITS-1:0] fire_set;
            in_table = idx < n_timers;
            fire_set = '0;
            case (op)
                ctt_pkg::OP_SET_TENTHS: begin
                    if (in_table) begin
                        counter[idx]    = amount;
                        reload_val[idx] = amount;
                    end
                end
                ctt_pkg::OP_SET_MST: begin
                    if (in_table) begin
                        total           = (mins * 600 + secs * 10 + amount[7:0]) * 100;
                        counter[idx]    = 16'(total);
                        reload_val[idx] = 16'(total);
                    end
                end
                ctt_pkg::OP_START: begin
                    if (in_table) enabled[idx] = 1'b1;
                end
                ctt_pkg::OP_STOP: begin
                    if (in_table) enabled[idx] = 1'b0;
                end
                ctt_pkg::OP_RELOAD: begin
                    if (in_table) counter[idx] = reload_val[idx];
                end
                ctt_pkg::OP_CHECK: begin
                    if (in_table) begin
                        expected_reports.push_back(make_report(3'(idx), counter[idx], 1'b0, 1'b1));
                    end else begin
                        expected_reports.push_back(make_report(3'd0, 16'd0, 1'b0, 1'b1));
                    end
                end
                ctt_pkg::OP_TICK: begin
                    for (int i = 0; i < n_timers; i++) begin
                        if (enabled[i] && counter[i] != 0) begin
                            counter[i] = counter[i] - 16'd1;
                            if (counter[i] == 0) expired_flag[i] = 1'b1;
                        end
                    end
                end
                ctt_pkg::OP_SERVICE: begin
                    // only timers with a mask bit can fire
                    for (int i = 0; i < n_timers && i < ctt_pkg::MASK_BITS; i++) begin
                        if (enabled[i] && expired_flag[i] && handler_mask[i]) fire_set[i] = 1'b1;
                    end
                    for (int i = 0; i < ctt_pkg::MASK_BITS; i++) begin
                        if (fire_set[i]) begin
                            expected_reports.push_back(make_report(3'(i), 16'd0, 1'b1,
                                                                   (fire_set >> (i + 1)) == 0));
                            expired_flag[i] = 1'b0;
                            counter[i]      = reload_val[i];
                            enabled[i]      = repeat_mask[i];
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function string fmt(t_timer_report r);
            return $sformatf("timer %0d rem %0d fired %0b digits %0d%0d:%0d%0d.%0d last %0b",
                             r.which_timer, r.remaining, r.fired, r.minute_tens,
                             r.minute_ones, r.second_tens, r.second_ones, r.tenth_digit,
                             r.last);
        endfunction

        function void check_report(t_timer_report got);
            t_timer_report want;
            if (got.fired) fires_seen++;
            else checks_seen++;
            if (expected_reports.size() == 0) begin
                if (mismatches < 10) $display("unexpected report: %s", fmt(got));
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                if (got !== want) begin
                    if (mismatches < 10) begin
                        $display("report mismatch\n  expected %s\n  actual   %s",
                                 fmt(want), fmt(got));
                    end
                    mismatches++;
                end
            end
        endfunction
    endclass

endpackage

/* tb/countdown_timer_table_top_tb.sv */
`timescale 1ns / 1ps
// countdown_timer_table_top_tb: directed and random operations against a scoreboard,
// with random idling on both channels. Depends on ctt_pkg, the ctt_*_if interfaces,
// ctt_tb_pkg and countdown_timer_table_top.

module countdown_timer_table_top_tb;

    localparam int TIMERS        = ctt_pkg::TIMERS_DEF;
    localparam int SETTLE_CYCLES = 2 * TIMERS + 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SEGMENT_ITEMS = 33;

    logic i_clk;
    logic i_rst_n;

    ctt_in_if  in_ch();
    ctt_out_if out_ch();
    ctt_cfg_if cfg_ch();

    countdown_timer_table_top #(.TIMERS(TIMERS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    ctt_tb_pkg::t_timer_table_scoreboard sb;
    int unsigned op_accepts  = 0;
    int unsigned cfg_accepts = 0;
    int unsigned cycles      = 0;
    int unsigned gap_pct     = 33;
    int unsigned stall_pct   = 76;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watch every transaction on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.apply_operation(in_ch.operation, in_ch.timer_index, in_ch.tenths_amount,
                                   in_ch.minutes, in_ch.seconds);
                op_accepts <= op_accepts + 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.check_report({out_ch.which_timer, out_ch.remaining, out_ch.fired,
                                 out_ch.minute_tens, out_ch.minute_ones, out_ch.second_tens,
                                 out_ch.second_ones, out_ch.tenth_digit, out_ch.last});
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.write_reg(cfg_ch.reg_index, cfg_ch.wr_data);
                cfg_accepts <= cfg_accepts + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_op(input logic [2:0] op, input logic [7:0] idx,
                           input logic [15:0] amount, input logic [7:0] mins,
                           input logic [7:0] secs);
        int unsigned seen;
        while ($urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= op;
        in_ch.timer_index   <= idx;
        in_ch.tenths_amount <= amount;
        in_ch.minutes       <= mins;
        in_ch.seconds       <= secs;
        seen = op_accepts;
        do @(negedge i_clk); while (op_accepts == seen);
    endtask

    task automatic cfg_write(input logic [ctt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ctt_pkg::CFG_DATA_W-1:0] data);
        int unsigned seen;
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= data;
        seen = cfg_accepts;
        do @(negedge i_clk); while (cfg_accepts == seen);
    endtask

    // back-to-back writes keep valid high between transactions
    task automatic program_masks(input logic [7:0] rep, input logic [7:0] hnd, input bit stray);
        cfg_write(ctt_pkg::REG_REPEAT, rep);
        cfg_write(ctt_pkg::REG_HANDLER, hnd);
        if (stray) begin
            cfg_write(8'd2, 8'($urandom));
            cfg_write(8'hFF, 8'($urandom));
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_op();
        int unsigned pick;
        logic [2:0]  op;
        logic [7:0]  idx;
        logic [15:0] amount;
        logic [7:0]  mins;
        logic [7:0]  secs;
        pick = $urandom_range(99);
        if (pick < 12) op = ctt_pkg::OP_SET_TENTHS;
        else if (pick < 18) op = ctt_pkg::OP_SET_MST;
        else if (pick < 30) op = ctt_pkg::OP_START;
        else if (pick < 35) op = ctt_pkg::OP_STOP;
        else if (pick < 41) op = ctt_pkg::OP_RELOAD;
        else if (pick < 55) op = ctt_pkg::OP_CHECK;
        else if (pick < 82) op = ctt_pkg::OP_TICK;
        else op = ctt_pkg::OP_SERVICE;
        if ($urandom_range(99) < 8) idx = 8'($urandom_range(255, TIMERS));
        else idx = 8'($urandom_range(TIMERS - 1));
        // short counts so timers actually run out
        amount = ($urandom_range(99) < 15) ? 16'($urandom) : 16'($urandom_range(6));
        mins   = ($urandom_range(1)) ? 8'($urandom) : 8'd0;
        secs   = ($urandom_range(1)) ? 8'($urandom) : 8'd0;
        send_op(op, idx, amount, mins, secs);
    endtask

    initial begin
        sb                  = new(TIMERS);
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.operation     = '0;
        in_ch.timer_index   = '0;
        in_ch.tenths_amount = '0;
        in_ch.minutes       = '0;
        in_ch.seconds       = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.reg_index    = '0;
        cfg_ch.wr_data      = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        program_masks(8'h00, 8'hFF, 1'b1);

        send_op(ctt_pkg::OP_CHECK, 8'd0, 16'd0, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_CHECK, 8'd8, 16'd0, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_CHECK, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_op(ctt_pkg::OP_SET_TENTHS, 8'd0, 16'hFFFF, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_CHECK, 8'd0, 16'd0, 8'd0, 8'd0);
        // minutes and seconds large enough to wrap
        send_op(ctt_pkg::OP_SET_MST, 8'd2, 16'hFFFF, 8'hFF, 8'hFF);
        send_op(ctt_pkg::OP_CHECK, 8'd2, 16'd0, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_SET_MST, 8'd3, 16'h0102, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_CHECK, 8'd3, 16'd0, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_SET_TENTHS, 8'd200, 16'd5, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_START, 8'd9, 16'd0, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_STOP, 8'hFF, 16'd0, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_RELOAD, 8'd130, 16'd0, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_SET_TENTHS, 8'd4, 16'd1, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_START, 8'd4, 16'd0, 8'd0, 8'd0);
        // running at zero: no decrement, never expires
        send_op(ctt_pkg::OP_START, 8'd1, 16'd0, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_SET_TENTHS, 8'd6, 16'd1, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_START, 8'd6, 16'd0, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_TICK, 8'd0, 16'd0, 8'd0, 8'd0);
        // timer 6 expired but stopped: it must wait
        send_op(ctt_pkg::OP_STOP, 8'd6, 16'd0, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_SERVICE, 8'd0, 16'd0, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_START, 8'd6, 16'd0, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_SERVICE, 8'd0, 16'd0, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_CHECK, 8'd4, 16'd0, 8'd0, 8'd0);
        send_op(ctt_pkg::OP_CHECK, 8'd6, 16'd0, 8'd0, 8'd0);
        drain();

        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin
                    gap_pct   = 33;
                    stall_pct = 76;
                end
                1: begin
                    gap_pct   = 76;
                    stall_pct = 33;
                end
                default: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase
            case (seg)
                1: program_masks(8'hFF, 8'h00, 1'b0);
                3: program_masks(8'hFF, 8'hFF, 1'b0);
                5: program_masks(8'h00, 8'($urandom), 1'b0);
                default: program_masks(8'($urandom), 8'($urandom), 1'b0);
            endcase
            repeat (SEGMENT_ITEMS) random_op();
            drain();
        end

        $display("covered %0d operations and %0d register writes over three idling phases",
                 op_accepts, cfg_accepts);
        $display("compared %0d check reports and %0d fired reports, %0d mismatches",
                 sb.checks_seen, sb.fires_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
